FILE: rtl/core/servo_status_frame_parser_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the servo status frame parser
// Shared property forms used by the parser's controller and datapath.
// ---------------------------------------------------------------------------
`ifndef SERVO_STATUS_FRAME_PARSER_ASSERT_SVH
`define SERVO_STATUS_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssfp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SSFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssfp assertion failed");

`endif

FILE: rtl/core/ssfp_pkg.sv
// ---------------------------------------------------------------------------
// Servo status frame parser package
// Constants, status codes and the controller/datapath signal groups.
// ---------------------------------------------------------------------------
package ssfp_pkg;

  // Parameter buffer depth and derived widths.
  localparam int MAX_PARAMS = 64;
  localparam int PIDX_W     = $clog2(MAX_PARAMS);

  // Frame constants.
  localparam logic [7:0] HDR_BYTE    = 8'hFF;
  localparam logic [6:0] MIN_LEN     = 7'd2;
  localparam logic [6:0] MAX_LEN_CAP = 7'(MAX_PARAMS + 2);

  // Configuration register reset values and indexes.
  localparam logic [7:0] SCAN_LIMIT_RST = 8'd50;
  localparam logic [6:0] MAX_LENGTH_RST = 7'd50;
  localparam int         CFG_IDX_W      = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 1'd1;

  // Result status codes.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_HDR   = 3'd1;
  localparam logic [2:0] ST_BAD_LEN  = 3'd2;
  localparam logic [2:0] ST_BAD_CHK  = 3'd3;
  localparam logic [2:0] ST_TIMEOUT  = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       ld_id;
    logic       ld_len;
    logic       ld_err;
    logic       ld_param;
    logic       drain_start;
    logic       drain_rd;
    logic       drain_emit;
    logic       emit_fail;
    logic       emit_empty;
    logic [2:0] fail_code;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic byte_is_hdr;
    logic len_bad;
    logic len_two;
    logic params_done;
    logic sum_ok;
    logic out_free;
    logic drain_last;
  } dp_status_t;

endpackage

FILE: rtl/core/ssfp_if.sv
// ---------------------------------------------------------------------------
// Servo status frame parser channels
// Valid/ready request channels for received bytes and parsed results.
// ---------------------------------------------------------------------------

// Received byte or timeout event.
interface ssfp_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

// Parsed result.
interface ssfp_out_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  status;
  logic [7:0]                  servo_id;
  logic [7:0]                  servo_error;
  logic [6:0]                  param_count;
  logic [ssfp_pkg::PIDX_W-1:0] param_index;
  logic [7:0]                  param_byte;
  logic                        last;

  modport source (output valid, output status, output servo_id, output servo_error,
                  output param_count, output param_index, output param_byte,
                  output last, input ready);
  modport sink   (input valid, input status, input servo_id, input servo_error,
                  input param_count, input param_index, input param_byte,
                  input last, output ready);
endinterface

FILE: rtl/core/ssfp_dp.sv
// ---------------------------------------------------------------------------
// Servo status frame parser datapath
// Frame fields, running checksum, parameter buffer and the result register.
// ---------------------------------------------------------------------------
`include "servo_status_frame_parser_assert.svh"

module ssfp_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           rx_byte,
  input  logic [6:0]           max_length,
  input  ssfp_pkg::dp_cmd_t    cmd,
  output ssfp_pkg::dp_status_t st,
  ssfp_out_if.source           out_ch
);

  logic [7:0]                  frame_id_r;
  logic [7:0]                  frame_error_r;
  logic [6:0]                  frame_length_r;
  logic [7:0]                  running_sum_r;
  logic [6:0]                  param_counter_r;
  logic [ssfp_pkg::PIDX_W-1:0] drain_idx_r;
  logic [7:0]                  rd_data_r;
  logic [7:0]                  param_mem [ssfp_pkg::MAX_PARAMS];

  logic                        out_valid_r;
  logic [2:0]                  out_status_r;
  logic [7:0]                  out_id_r;
  logic [7:0]                  out_error_r;
  logic [6:0]                  out_count_r;
  logic [ssfp_pkg::PIDX_W-1:0] out_index_r;
  logic [7:0]                  out_byte_r;
  logic                        out_last_r;

  logic [6:0] param_total;
  logic       out_load;

  // Number of parameter bytes; only meaningful once the length passed its check.
  assign param_total = frame_length_r - ssfp_pkg::MIN_LEN;
  assign out_load    = cmd.emit_fail || cmd.emit_empty || cmd.drain_emit;

  // Status toward the controller.
  always_comb begin
    st.byte_is_hdr = (rx_byte == ssfp_pkg::HDR_BYTE);
    st.len_bad     = (frame_length_r < ssfp_pkg::MIN_LEN) ||
                     (frame_length_r > max_length) ||
                     (frame_length_r > ssfp_pkg::MAX_LEN_CAP);
    st.len_two     = (frame_length_r == ssfp_pkg::MIN_LEN);
    st.params_done = ({1'b0, param_counter_r} + 8'd1) >= {1'b0, param_total};
    st.sum_ok      = (rx_byte == ~running_sum_r);
    st.out_free    = !out_valid_r || out_ch.ready;
    st.drain_last  = (7'(drain_idx_r) + 7'd1) == param_total;
  end

  // Frame header fields and the running checksum.
  always_ff @(posedge clk) begin
    if (cmd.ld_id) begin
      frame_id_r    <= rx_byte;
      running_sum_r <= rx_byte;
    end
    if (cmd.ld_len || cmd.ld_err || cmd.ld_param) begin
      running_sum_r <= running_sum_r + rx_byte;
    end
    if (cmd.ld_len) begin
      frame_length_r <= rx_byte[7] ? 7'h7F : rx_byte[6:0];
    end
    if (cmd.ld_err) begin
      frame_error_r <= rx_byte;
    end
  end

  // Parameter write counter and drain read index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      param_counter_r <= '0;
      drain_idx_r     <= '0;
    end else begin
      if (cmd.ld_err) begin
        param_counter_r <= '0;
      end else if (cmd.ld_param) begin
        param_counter_r <= param_counter_r + 7'd1;
      end
      if (cmd.drain_start) begin
        drain_idx_r <= '0;
      end else if (cmd.drain_emit) begin
        drain_idx_r <= drain_idx_r + {{(ssfp_pkg::PIDX_W-1){1'b0}}, 1'b1};
      end
    end
  end

  // Parameter buffer: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.ld_param) begin
      param_mem[param_counter_r[ssfp_pkg::PIDX_W-1:0]] <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.drain_rd) begin
      rd_data_r <= param_mem[drain_idx_r];
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (cmd.emit_fail) begin
      out_status_r <= cmd.fail_code;
      out_id_r     <= '0;
      out_error_r  <= '0;
      out_count_r  <= '0;
      out_index_r  <= '0;
      out_byte_r   <= '0;
      out_last_r   <= 1'b1;
    end else if (cmd.emit_empty) begin
      out_status_r <= ssfp_pkg::ST_OK;
      out_id_r     <= frame_id_r;
      out_error_r  <= frame_error_r;
      out_count_r  <= '0;
      out_index_r  <= '0;
      out_byte_r   <= '0;
      out_last_r   <= 1'b1;
    end else if (cmd.drain_emit) begin
      out_status_r <= ssfp_pkg::ST_OK;
      out_id_r     <= frame_id_r;
      out_error_r  <= frame_error_r;
      out_count_r  <= param_total;
      out_index_r  <= drain_idx_r;
      out_byte_r   <= rd_data_r;
      out_last_r   <= st.drain_last;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.servo_id    = out_id_r;
  assign out_ch.servo_error = out_error_r;
  assign out_ch.param_count = out_count_r;
  assign out_ch.param_index = out_index_r;
  assign out_ch.param_byte  = out_byte_r;
  assign out_ch.last        = out_last_r;

  // A new result never overwrites one that is still waiting.
  `SSFP_ASSERT_IMP(a_load_free, clk, rst_n, out_load, st.out_free)
  // Parameter writes stay inside the buffer.
  `SSFP_ASSERT_IMP(a_param_in_range, clk, rst_n, cmd.ld_param,
                   param_counter_r < 7'(ssfp_pkg::MAX_PARAMS))
  // Every failure result closes its frame.
  `SSFP_ASSERT_IMP(a_fail_is_last, clk, rst_n,
                   out_valid_r && (out_status_r != ssfp_pkg::ST_OK), out_last_r)

endmodule

FILE: rtl/core/ssfp_ctrl.sv
// ---------------------------------------------------------------------------
// Servo status frame parser controller
// Frame phase state machine, header hunt counters and result sequencing.
// ---------------------------------------------------------------------------
`include "servo_status_frame_parser_assert.svh"

module ssfp_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_mode,
  input  logic [7:0]           scan_limit,
  input  ssfp_pkg::dp_status_t st,
  output logic                 in_ready,
  output ssfp_pkg::dp_cmd_t    cmd
);

  localparam logic [2:0] S_HUNT  = 3'd0;
  localparam logic [2:0] S_ID    = 3'd1;
  localparam logic [2:0] S_LEN   = 3'd2;
  localparam logic [2:0] S_ERR   = 3'd3;
  localparam logic [2:0] S_PARAM = 3'd4;
  localparam logic [2:0] S_CHK   = 3'd5;
  localparam logic [2:0] S_DRD   = 3'd6;
  localparam logic [2:0] S_DWR   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [1:0] run_r, run_nxt;
  logic [7:0] scan_r, scan_nxt;

  logic       accept;
  logic [7:0] lim;
  logic [7:0] scan_inc;
  logic [1:0] run_inc;

  // Bytes are taken in the parsing phases whenever the result slot can take a result.
  assign in_ready = (state_r != S_DRD) && (state_r != S_DWR) && st.out_free;
  assign accept   = in_valid && in_ready;

  // Header hunt arithmetic; a limit of zero acts as one.
  assign lim      = (scan_limit == 8'd0) ? 8'd1 : scan_limit;
  assign scan_inc = (scan_r == 8'hFF) ? scan_r : scan_r + 8'd1;
  assign run_inc  = st.byte_is_hdr ? ((run_r == 2'd2) ? run_r : run_r + 2'd1) : 2'd0;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    run_nxt   = run_r;
    scan_nxt  = scan_r;
    cmd       = '0;
    if (accept && in_mode) begin
      cmd.emit_fail = 1'b1;
      cmd.fail_code = ssfp_pkg::ST_TIMEOUT;
      state_nxt     = S_HUNT;
      run_nxt       = '0;
      scan_nxt      = '0;
    end else begin
      case (state_r)
        S_HUNT: begin
          if (accept) begin
            run_nxt  = run_inc;
            scan_nxt = scan_inc;
            if (run_inc == 2'd2) begin
              state_nxt = S_ID;
              run_nxt   = '0;
              scan_nxt  = '0;
            end else if (scan_inc >= lim) begin
              cmd.emit_fail = 1'b1;
              cmd.fail_code = ssfp_pkg::ST_NO_HDR;
              run_nxt       = '0;
              scan_nxt      = '0;
            end
          end
        end
        S_ID: begin
          if (accept) begin
            cmd.ld_id = 1'b1;
            state_nxt = S_LEN;
          end
        end
        S_LEN: begin
          if (accept) begin
            cmd.ld_len = 1'b1;
            state_nxt  = S_ERR;
          end
        end
        S_ERR: begin
          if (accept) begin
            cmd.ld_err = 1'b1;
            if (st.len_bad) begin
              cmd.emit_fail = 1'b1;
              cmd.fail_code = ssfp_pkg::ST_BAD_LEN;
              state_nxt     = S_HUNT;
            end else begin
              state_nxt = st.len_two ? S_CHK : S_PARAM;
            end
          end
        end
        S_PARAM: begin
          if (accept) begin
            cmd.ld_param = 1'b1;
            if (st.params_done) begin
              state_nxt = S_CHK;
            end
          end
        end
        S_CHK: begin
          if (accept) begin
            if (!st.sum_ok) begin
              cmd.emit_fail = 1'b1;
              cmd.fail_code = ssfp_pkg::ST_BAD_CHK;
              state_nxt     = S_HUNT;
            end else if (st.len_two) begin
              cmd.emit_empty = 1'b1;
              state_nxt      = S_HUNT;
            end else begin
              cmd.drain_start = 1'b1;
              state_nxt       = S_DRD;
            end
          end
        end
        S_DRD: begin
          cmd.drain_rd = 1'b1;
          state_nxt    = S_DWR;
        end
        S_DWR: begin
          if (st.out_free) begin
            cmd.drain_emit = 1'b1;
            state_nxt      = st.drain_last ? S_HUNT : S_DRD;
          end
        end
        default: begin
          state_nxt = S_HUNT;
          run_nxt   = '0;
          scan_nxt  = '0;
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HUNT;
      run_r   <= '0;
      scan_r  <= '0;
    end else begin
      state_r <= state_nxt;
      run_r   <= run_nxt;
      scan_r  <= scan_nxt;
    end
  end

  // A timeout always sends the parser back to the hunt.
  `SSFP_ASSERT_NEXT(a_timeout_hunt, clk, rst_n, accept && in_mode, state_r == S_HUNT)
  // A buffer read is always followed by its result slot.
  `SSFP_ASSERT_NEXT(a_read_then_emit, clk, rst_n, state_r == S_DRD, state_r == S_DWR)
  // At most one result source per cycle.
  `SSFP_ASSERT_IMP(a_one_source, clk, rst_n, 1'b1,
                   $onehot0({cmd.emit_fail, cmd.emit_empty, cmd.drain_emit}))

endmodule

FILE: rtl/core/servo_status_frame_parser.sv
// ---------------------------------------------------------------------------
// Servo status frame parser
// Parses protocol-1 style status frames from a half-duplex servo bus.
// ---------------------------------------------------------------------------
// Each input request is a received byte or a response timeout event. While
// parsing, one byte is taken per clock cycle, as long as the result register
// is empty or being emptied in that cycle. After a frame with a good checksum
// and n parameter bytes, the parameters are read back from a 64-entry buffer
// with a registered read port, so the frame drains as n results, each read
// from the buffer and then loaded into the result register once it is free,
// and no input is taken during that drain. Failures and frames without
// parameters give a single result in the cycle after the byte that decides
// them. Configuration registers are written through the cfg_ port: index 0
// is the header scan limit, index 1 the largest accepted length byte.

module servo_status_frame_parser (
  input  logic                             clk,
  input  logic                             rst_n,
  ssfp_in_if.sink                          in_ch,
  ssfp_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [ssfp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                       cfg_wdata
);

  logic [7:0]           scan_limit_r;
  logic [6:0]           max_length_r;
  ssfp_pkg::dp_cmd_t    cmd;
  ssfp_pkg::dp_status_t st;
  logic                 in_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_limit_r <= ssfp_pkg::SCAN_LIMIT_RST;
      max_length_r <= ssfp_pkg::MAX_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ssfp_pkg::CFG_SCAN_LIMIT: scan_limit_r <= cfg_wdata;
        ssfp_pkg::CFG_MAX_LENGTH: max_length_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = in_ready;

  // Controller.
  ssfp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_mode    (in_ch.mode),
    .scan_limit (scan_limit_r),
    .st         (st),
    .in_ready   (in_ready),
    .cmd        (cmd)
  );

  // Datapath.
  ssfp_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .rx_byte    (in_ch.rx_byte),
    .max_length (max_length_r),
    .cmd        (cmd),
    .st         (st),
    .out_ch     (out_ch)
  );

endmodule
